FILE: hw/rtl/segment_circle_intersect_core_assert.svh
// Assertion macros used by the checker file of the segment-circle core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SEGMENT_CIRCLE_INTERSECT_CORE_ASSERT_SVH
`define SEGMENT_CIRCLE_INTERSECT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication that checks the consequent a fixed number of cycles later.
`define SCI_ASSERT_AFTER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sci_pkg.sv
// Shared widths, side-band types and latency of the segment-circle core.
// No dependencies; every module of the core imports this package.
package sci_pkg;

  localparam int COORD_BITS = 24;
  localparam int DW   = COORD_BITS + 1;       // coordinate differences
  localparam int MW   = 2 * COORD_BITS + 1;   // magnitudes of A, H and C
  localparam int LOW  = DW;                   // low slice for split products
  localparam int HIW  = MW - LOW;             // high slice for split products
  localparam int SW   = MW + 1;               // signed H and C
  localparam int PW   = 2 * MW;               // H^2 and A*|C|
  localparam int QW   = PW + 2;               // signed discriminant
  localparam int SQW  = 4 * COORD_BITS;       // nonnegative discriminant
  localparam int RW   = 2 * COORD_BITS;       // square root
  localparam int NW   = MW + 2;               // signed root numerators
  localparam int NUMW = MW + DW + 1;          // rounding dividend
  localparam int DENW = MW + 1;               // rounding divisor 2A
  localparam int QTW  = COORD_BITS;           // axis offset magnitude
  localparam int SUMW = COORD_BITS + 2;       // point before saturation
  localparam int LATENCY = 10 + RW + QTW;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;

  typedef struct packed {
    logic [MW-1:0]        a;
    logic signed [SW-1:0] h;
    coord_t               sx;
    coord_t               sy;
    diff_t                dx;
    diff_t                dy;
    logic                 ok;   // nonzero length and nonnegative discriminant
  } sq_side_t;

  typedef struct packed {
    logic   hit;
    coord_t sx;
    coord_t sy;
    logic   dx_neg;
    logic   dy_neg;
  } dv_side_t;

endpackage

FILE: hw/rtl/segment_circle_intersect_core.sv
// Top level of the segment versus circle boundary intersection core.
// Instantiates sci_sqrt_pipe and sci_div_pipe; depends on sci_pkg.

// A request is taken whenever start is high; busy is always low, so a new request may be
// issued in every cycle. Each request yields exactly one result, shown for one cycle with
// out_valid. The result cannot be held off, so the receiver must take it in that cycle. The
// pipeline holds the square root, one bit per stage over 48 stages, and the rounding
// divider, one offset bit per stage over 24 stages, plus ten stages of multiply, add and
// select around them. Coordinates are signed Q15.8; a miss reports out_hit low and a zero
// point.
module segment_circle_intersect_core import sci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  coord_t                in_start_x,
  input  coord_t                in_start_y,
  input  coord_t                in_end_x,
  input  coord_t                in_end_y,
  input  coord_t                in_center_x,
  input  coord_t                in_center_y,
  input  logic [COORD_BITS-2:0] in_circle_radius,
  output logic                  out_valid,
  output logic                  out_hit,
  output coord_t                out_point_x,
  output coord_t                out_point_y
);

  function automatic coord_t sat_coord(input logic signed [SUMW-1:0] v);
    coord_t res;
    if (!v[SUMW-1] && (v[SUMW-2:COORD_BITS-1] != '0)) begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (v[SUMW-1] && (v[SUMW-2:COORD_BITS-1] != '1)) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // Stage 1: differences.
  logic v1_r;
  coord_t sx1_r, sy1_r;
  diff_t dx1_r, dy1_r, fx1_r, fy1_r;
  logic [COORD_BITS-2:0] r1_r;

  // Stage 2: products of differences.
  logic v2_r;
  coord_t sx2_r, sy2_r;
  diff_t dx2_r, dy2_r;
  logic signed [SW-1:0] xx2_r, yy2_r, fdx2_r, fdy2_r, ffx2_r, ffy2_r;
  logic [2*COORD_BITS-3:0] rr2_r;

  // Stage 3: A, H and C.
  logic v3_r;
  coord_t sx3_r, sy3_r;
  diff_t dx3_r, dy3_r;
  logic [MW-1:0] a3_r;
  logic signed [SW-1:0] h3_r, c3_r;

  // Stage 4: split partial products of H*H and A*|C|.
  logic [MW-1:0] hmag, cmag;
  logic v4_r, cneg4_r;
  coord_t sx4_r, sy4_r;
  diff_t dx4_r, dy4_r;
  logic [MW-1:0] a4_r;
  logic signed [SW-1:0] h4_r;
  logic [2*HIW-1:0] hh_hh4_r, ac_hh4_r;
  logic [HIW+LOW-1:0] hh_hl4_r, ac_hl4_r, ac_lh4_r;
  logic [2*LOW-1:0] hh_ll4_r, ac_ll4_r;

  // Stage 5: full products.
  logic v5_r, cneg5_r;
  coord_t sx5_r, sy5_r;
  diff_t dx5_r, dy5_r;
  logic [MW-1:0] a5_r;
  logic signed [SW-1:0] h5_r;
  logic [PW-1:0] hsq5_r, acm5_r;

  // Stage 6: discriminant.
  logic signed [QW-1:0] qv;
  sq_side_t side6_nxt;
  logic v6_r;
  logic [SQW-1:0] rad6_r;
  sq_side_t side6_r;

  logic sq_v;
  logic [RW-1:0] sq_root;
  sq_side_t sq_side;

  // Stage 7: root selection.
  logic signed [NW-1:0] nh, n1, n2, s_ext, a_ext, m1, m2;
  logic ok1, ok2;
  logic v7_r, hit7_r;
  coord_t sx7_r, sy7_r;
  diff_t dx7_r, dy7_r;
  logic [MW-1:0] a7_r, n7_r;

  // Stage 8: offset products.
  logic [DW-1:0] dxmag, dymag;
  logic v8_r, hit8_r, dxneg8_r, dyneg8_r;
  coord_t sx8_r, sy8_r;
  logic [MW-1:0] a8_r;
  logic [DW+LOW-1:0] xlo8_r, ylo8_r;
  logic [DW+HIW-1:0] xhi8_r, yhi8_r;

  // Stage 9: rounding dividend and divisor.
  logic v9_r;
  logic [NUMW-1:0] numx9_r, numy9_r;
  logic [DENW-1:0] den9_r;
  dv_side_t side9_r;

  logic dv_v;
  logic [QTW-1:0] dv_qx, dv_qy;
  dv_side_t dv_side;

  logic signed [SUMW-1:0] qxe, qye, sumx, sumy;
  logic out_valid_r, out_hit_r;
  coord_t out_point_x_r, out_point_y_r;

  // The pipeline never refuses a request.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    sx1_r <= in_start_x;
    sy1_r <= in_start_y;
    dx1_r <= diff_t'(in_end_x) - diff_t'(in_start_x);
    dy1_r <= diff_t'(in_end_y) - diff_t'(in_start_y);
    fx1_r <= diff_t'(in_start_x) - diff_t'(in_center_x);
    fy1_r <= diff_t'(in_start_y) - diff_t'(in_center_y);
    r1_r  <= in_circle_radius;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
    xx2_r  <= dx1_r * dx1_r;
    yy2_r  <= dy1_r * dy1_r;
    fdx2_r <= fx1_r * dx1_r;
    fdy2_r <= fy1_r * dy1_r;
    ffx2_r <= fx1_r * fx1_r;
    ffy2_r <= fy1_r * fy1_r;
    rr2_r  <= r1_r * r1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sx3_r <= sx2_r;
    sy3_r <= sy2_r;
    dx3_r <= dx2_r;
    dy3_r <= dy2_r;
    a3_r  <= MW'(xx2_r + yy2_r);
    h3_r  <= fdx2_r + fdy2_r;
    c3_r  <= ffx2_r + ffy2_r - $signed({{(SW-2*COORD_BITS+2){1'b0}}, rr2_r});
  end

  assign hmag = MW'(h3_r[SW-1] ? -h3_r : h3_r);
  assign cmag = MW'(c3_r[SW-1] ? -c3_r : c3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sx4_r    <= sx3_r;
    sy4_r    <= sy3_r;
    dx4_r    <= dx3_r;
    dy4_r    <= dy3_r;
    a4_r     <= a3_r;
    h4_r     <= h3_r;
    cneg4_r  <= c3_r[SW-1];
    hh_hh4_r <= hmag[MW-1:LOW] * hmag[MW-1:LOW];
    hh_hl4_r <= hmag[MW-1:LOW] * hmag[LOW-1:0];
    hh_ll4_r <= hmag[LOW-1:0] * hmag[LOW-1:0];
    ac_hh4_r <= a3_r[MW-1:LOW] * cmag[MW-1:LOW];
    ac_hl4_r <= a3_r[MW-1:LOW] * cmag[LOW-1:0];
    ac_lh4_r <= a3_r[LOW-1:0] * cmag[MW-1:LOW];
    ac_ll4_r <= a3_r[LOW-1:0] * cmag[LOW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    sx5_r   <= sx4_r;
    sy5_r   <= sy4_r;
    dx5_r   <= dx4_r;
    dy5_r   <= dy4_r;
    a5_r    <= a4_r;
    h5_r    <= h4_r;
    cneg5_r <= cneg4_r;
    // The cross term of H*H appears twice, hence the extra shift.
    hsq5_r  <= (PW'(hh_hh4_r) << (2*LOW)) + (PW'(hh_hl4_r) << (LOW+1)) + PW'(hh_ll4_r);
    acm5_r  <= (PW'(ac_hh4_r) << (2*LOW)) + ((PW'(ac_hl4_r) + PW'(ac_lh4_r)) << LOW)
               + PW'(ac_ll4_r);
  end

  assign qv = $signed(QW'(hsq5_r))
              - (cneg5_r ? -$signed(QW'(acm5_r)) : $signed(QW'(acm5_r)));

  always_comb begin
    side6_nxt.a  = a5_r;
    side6_nxt.h  = h5_r;
    side6_nxt.sx = sx5_r;
    side6_nxt.sy = sy5_r;
    side6_nxt.dx = dx5_r;
    side6_nxt.dy = dy5_r;
    side6_nxt.ok = !qv[QW-1] && (a5_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    // A nonnegative discriminant is at most A*r^2, which fits the low SQW bits.
    rad6_r  <= qv[SQW-1:0];
    side6_r <= side6_nxt;
  end

  sci_sqrt_pipe u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v6_r),
    .rad_i  (rad6_r),
    .side_i (side6_r),
    .v_o    (sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign nh    = -NW'(sq_side.h);
  assign s_ext = $signed(NW'(sq_root));
  assign a_ext = $signed(NW'(sq_side.a));
  assign n1    = nh - s_ext;
  assign n2    = nh + s_ext;
  assign m1    = a_ext - n1;
  assign m2    = a_ext - n2;
  assign ok1   = !n1[NW-1] && !m1[NW-1];
  assign ok2   = !n2[NW-1] && !m2[NW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= sq_v;
    end
    hit7_r <= sq_side.ok && (ok1 || ok2);
    n7_r   <= ok1 ? n1[MW-1:0] : n2[MW-1:0];
    a7_r   <= sq_side.a;
    sx7_r  <= sq_side.sx;
    sy7_r  <= sq_side.sy;
    dx7_r  <= sq_side.dx;
    dy7_r  <= sq_side.dy;
  end

  assign dxmag = DW'(dx7_r[DW-1] ? -dx7_r : dx7_r);
  assign dymag = DW'(dy7_r[DW-1] ? -dy7_r : dy7_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    hit8_r   <= hit7_r;
    a8_r     <= a7_r;
    sx8_r    <= sx7_r;
    sy8_r    <= sy7_r;
    dxneg8_r <= dx7_r[DW-1];
    dyneg8_r <= dy7_r[DW-1];
    xlo8_r   <= dxmag * n7_r[LOW-1:0];
    xhi8_r   <= dxmag * n7_r[MW-1:LOW];
    ylo8_r   <= dymag * n7_r[LOW-1:0];
    yhi8_r   <= dymag * n7_r[MW-1:LOW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    // Round to nearest, ties away from zero: (2*|d|*n + A) / (2*A).
    numx9_r <= (((NUMW'(xhi8_r) << LOW) + NUMW'(xlo8_r)) << 1) + NUMW'(a8_r);
    numy9_r <= (((NUMW'(yhi8_r) << LOW) + NUMW'(ylo8_r)) << 1) + NUMW'(a8_r);
    den9_r  <= {a8_r, 1'b0};
    side9_r.hit    <= hit8_r;
    side9_r.sx     <= sx8_r;
    side9_r.sy     <= sy8_r;
    side9_r.dx_neg <= dxneg8_r;
    side9_r.dy_neg <= dyneg8_r;
  end

  sci_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (v9_r),
    .num_x_i (numx9_r),
    .num_y_i (numy9_r),
    .den_i   (den9_r),
    .side_i  (side9_r),
    .v_o     (dv_v),
    .q_x_o   (dv_qx),
    .q_y_o   (dv_qy),
    .side_o  (dv_side)
  );

  assign qxe  = $signed(SUMW'(dv_qx));
  assign qye  = $signed(SUMW'(dv_qy));
  assign sumx = SUMW'(dv_side.sx) + (dv_side.dx_neg ? -qxe : qxe);
  assign sumy = SUMW'(dv_side.sy) + (dv_side.dy_neg ? -qye : qye);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
    out_hit_r     <= dv_side.hit;
    out_point_x_r <= dv_side.hit ? sat_coord(sumx) : '0;
    out_point_y_r <= dv_side.hit ? sat_coord(sumy) : '0;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_point_x = out_point_x_r;
  assign out_point_y = out_point_y_r;

endmodule

FILE: hw/rtl/sci_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on sci_pkg for widths and the side-band type.
module sci_sqrt_pipe import sci_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           v_i,
  input  logic [SQW-1:0] rad_i,
  input  sq_side_t       side_i,
  output logic           v_o,
  output logic [RW-1:0]  root_o,
  output sq_side_t       side_o
);

  localparam int RMW = RW + 2;

  logic           v_r    [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [SQW-1:0] rad_r  [RW];
  sq_side_t       side_r [RW];

  logic [RMW-1:0] in_rem  [RW];
  logic [RW-1:0]  in_root [RW];
  logic [SQW-1:0] in_rad  [RW];
  logic [RMW-1:0] cur     [RW];
  logic [RMW-1:0] trial   [RW];
  logic [RW-1:0]  ge;

  always_comb begin
    in_rem[0]  = '0;
    in_root[0] = '0;
    in_rad[0]  = rad_i;
    for (int i = 1; i < RW; i++) begin
      in_rem[i]  = rem_r[i-1];
      in_root[i] = root_r[i-1];
      in_rad[i]  = rad_r[i-1];
    end
    // Each stage brings down the next two radicand bits and tries 4*root+1.
    for (int i = 0; i < RW; i++) begin
      cur[i]   = {in_rem[i][RMW-3:0], in_rad[i][SQW-1-2*i -: 2]};
      trial[i] = {in_root[i], 2'b01};
      ge[i]    = cur[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RW; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= v_i;
      for (int i = 1; i < RW; i++) v_r[i] <= v_r[i-1];
    end
    side_r[0] <= side_i;
    for (int i = 1; i < RW; i++) side_r[i] <= side_r[i-1];
    for (int i = 0; i < RW; i++) begin
      rem_r[i]  <= ge[i] ? cur[i] - trial[i] : cur[i];
      root_r[i] <= {in_root[i][RW-2:0], ge[i]};
      rad_r[i]  <= in_rad[i];
    end
  end

  assign v_o    = v_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

FILE: hw/rtl/sci_div_pipe.sv
// Pipelined restoring divider for the x and y offsets, one quotient bit per stage.
// Both lanes share the divisor; depends on sci_pkg.
module sci_div_pipe import sci_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            v_i,
  input  logic [NUMW-1:0] num_x_i,
  input  logic [NUMW-1:0] num_y_i,
  input  logic [DENW-1:0] den_i,
  input  dv_side_t        side_i,
  output logic            v_o,
  output logic [QTW-1:0]  q_x_o,
  output logic [QTW-1:0]  q_y_o,
  output dv_side_t        side_o
);

  localparam int RMW = DENW + 1;

  logic            v_r    [QTW];
  logic [RMW-1:0]  rx_r   [QTW];
  logic [RMW-1:0]  ry_r   [QTW];
  logic [QTW-1:0]  qx_r   [QTW];
  logic [QTW-1:0]  qy_r   [QTW];
  logic [NUMW-1:0] nx_r   [QTW];
  logic [NUMW-1:0] ny_r   [QTW];
  logic [DENW-1:0] den_r  [QTW];
  dv_side_t        side_r [QTW];

  logic [RMW-1:0]  in_rx  [QTW];
  logic [RMW-1:0]  in_ry  [QTW];
  logic [QTW-1:0]  in_qx  [QTW];
  logic [QTW-1:0]  in_qy  [QTW];
  logic [NUMW-1:0] in_nx  [QTW];
  logic [NUMW-1:0] in_ny  [QTW];
  logic [DENW-1:0] in_den [QTW];
  logic [RMW-1:0]  cx     [QTW];
  logic [RMW-1:0]  cy     [QTW];
  logic [RMW-1:0]  dext   [QTW];
  logic [QTW-1:0]  gx;
  logic [QTW-1:0]  gy;

  always_comb begin
    // The quotient fits in QTW bits, so the top of the dividend starts below the divisor.
    in_rx[0]  = num_x_i[NUMW-1:QTW];
    in_ry[0]  = num_y_i[NUMW-1:QTW];
    in_qx[0]  = '0;
    in_qy[0]  = '0;
    in_nx[0]  = num_x_i;
    in_ny[0]  = num_y_i;
    in_den[0] = den_i;
    for (int j = 1; j < QTW; j++) begin
      in_rx[j]  = rx_r[j-1];
      in_ry[j]  = ry_r[j-1];
      in_qx[j]  = qx_r[j-1];
      in_qy[j]  = qy_r[j-1];
      in_nx[j]  = nx_r[j-1];
      in_ny[j]  = ny_r[j-1];
      in_den[j] = den_r[j-1];
    end
    for (int j = 0; j < QTW; j++) begin
      dext[j] = {1'b0, in_den[j]};
      cx[j]   = {in_rx[j][RMW-2:0], in_nx[j][QTW-1-j]};
      cy[j]   = {in_ry[j][RMW-2:0], in_ny[j][QTW-1-j]};
      gx[j]   = cx[j] >= dext[j];
      gy[j]   = cy[j] >= dext[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QTW; j++) v_r[j] <= 1'b0;
    end else begin
      v_r[0] <= v_i;
      for (int j = 1; j < QTW; j++) v_r[j] <= v_r[j-1];
    end
    side_r[0] <= side_i;
    for (int j = 1; j < QTW; j++) side_r[j] <= side_r[j-1];
    for (int j = 0; j < QTW; j++) begin
      rx_r[j]  <= gx[j] ? cx[j] - dext[j] : cx[j];
      ry_r[j]  <= gy[j] ? cy[j] - dext[j] : cy[j];
      qx_r[j]  <= {in_qx[j][QTW-2:0], gx[j]};
      qy_r[j]  <= {in_qy[j][QTW-2:0], gy[j]};
      nx_r[j]  <= in_nx[j];
      ny_r[j]  <= in_ny[j];
      den_r[j] <= in_den[j];
    end
  end

  assign v_o    = v_r[QTW-1];
  assign q_x_o  = qx_r[QTW-1];
  assign q_y_o  = qy_r[QTW-1];
  assign side_o = side_r[QTW-1];

endmodule

FILE: hw/rtl/sci_checker.sv
// Port-level checks for segment_circle_intersect_core, bound to the top level.
// Depends on sci_pkg and the assertion macro header.
`include "segment_circle_intersect_core_assert.svh"

module sci_checker import sci_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input coord_t                in_start_x,
  input coord_t                in_start_y,
  input coord_t                in_end_x,
  input coord_t                in_end_y,
  input logic                  out_valid,
  input logic                  out_hit,
  input coord_t                out_point_x,
  input coord_t                out_point_y
);

  // Every request produces its result after the fixed pipeline latency.
  `SCI_ASSERT_AFTER(a_req_to_result, start && !busy, LATENCY, out_valid, "result missing after request")

  // A result only appears where a request entered the latency earlier.
  `SCI_ASSERT_IMPLIES(a_result_has_req, out_valid, $past(start && !busy, LATENCY), "result without request")

  // A miss reports the origin.
  `SCI_ASSERT_IMPLIES(a_miss_zero, out_valid && !out_hit, out_point_x == '0 && out_point_y == '0, "miss with nonzero point")

  // A segment of zero length never hits.
  `SCI_ASSERT_AFTER(a_zero_len, start && !busy && in_start_x == in_end_x && in_start_y == in_end_y, LATENCY, !out_hit, "zero-length segment reported a hit")

endmodule

bind segment_circle_intersect_core sci_checker u_sci_checker (.*);
